[rtl/apa_pkg.sv]
package apa_pkg;

  localparam int MaxRadius  = 100;
  localparam int PixelBits  = 16;
  localparam int QueueDepth = 2;

  localparam int PixW     = 16;
  localparam int OffW     = 8;
  localparam int RadW     = 15;
  localparam int LimW     = 16;
  localparam int SkyW     = 24;
  localparam int GainW    = 16;
  localparam int AreaW    = 24;
  localparam int FluxW    = 40;
  localparam int NoiseW   = 40;
  localparam int RsqW     = 16;
  localparam int DistW    = 32;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  localparam logic [RadW-1:0]  RadMax   = RadW'(MaxRadius * 256);
  localparam logic [PixW-1:0]  PixMask  = (PixelBits >= PixW) ? {PixW{1'b1}}
                                          : PixW'((1 << PixelBits) - 1);
  localparam logic [AreaW-1:0] AreaOne  = AreaW'(256);
  localparam logic [8:0]       WeightOne = 9'd256;
  localparam logic [7:0]       HalfQ8   = 8'd128;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RADIUS = 3'd0,
    CFG_LOW    = 3'd1,
    CFG_HIGH   = 3'd2,
    CFG_SKY    = 3'd3,
    CFG_SPREAD = 3'd4,
    CFG_GAIN   = 3'd5,
    CFG_NSKY   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [RadW-1:0]  radius;
    logic [LimW-1:0]  low;
    logic [LimW-1:0]  high;
    logic [SkyW-1:0]  sky;
    logic [SkyW-1:0]  spread;
    logic [GainW-1:0] gain;
    logic [GainW-1:0] nsky;
    logic [DistW-1:0] outer;
    logic [DistW-1:0] inner;
  } apa_cfg_t;

  // one classified pixel on its way to the accumulator
  typedef struct packed {
    logic [PixW-1:0] pix;
    logic [RsqW-1:0] rsq;
    logic            in_ap;
    logic            on_ring;
    logic            last;
  } apa_entry_t;

  function automatic logic [RadW-1:0] clamp_radius(input logic [RadW-1:0] r);
    return (r > RadMax) ? RadMax : r;
  endfunction

  function automatic logic [DistW-1:0] outer_of(input logic [RadW-1:0] r);
    logic [15:0] t;
    t = {1'b0, r} + {8'h0, HalfQ8};
    return DistW'(t) * DistW'(t);
  endfunction

  function automatic logic [DistW-1:0] inner_of(input logic [RadW-1:0] r);
    logic [15:0] t;
    t = (r >= RadW'(HalfQ8)) ? ({1'b0, r} - {8'h0, HalfQ8}) : ({8'h0, HalfQ8} - {1'b0, r});
    return DistW'(t) * DistW'(t);
  endfunction

endpackage

[rtl/apa_if.sv]
interface apa_pix_if;
  logic                    valid;
  logic                    ready;
  logic [15:0]             pixel_value;
  logic signed [7:0]       offset_x;
  logic signed [7:0]       offset_y;
  logic                    last_pixel;

  modport source (output valid, pixel_value, offset_x, offset_y, last_pixel, input ready);
  modport sink (input valid, pixel_value, offset_x, offset_y, last_pixel, output ready);
endinterface

interface apa_res_if;
  logic                    valid;
  logic                    ready;
  logic signed [39:0]      net_signal;
  logic [39:0]             noise_level;
  logic [23:0]             aperture_area;
  logic                    result_valid;
  logic                    noise_valid;

  modport source (output valid, net_signal, noise_level, aperture_area, result_valid,
                  noise_valid, input ready);
  modport sink (input valid, net_signal, noise_level, aperture_area, result_valid,
                noise_valid, output ready);
endinterface

[rtl/apa_fifo.sv]
module apa_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        mem_q[wr_ptr_q] <= wdata_i;
        wr_ptr_q <= (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end
endmodule

[rtl/apa_isqrt.sv]
module apa_isqrt #(
  parameter int W = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [2*W-1:0] op_i,
  output logic           done_o,
  output logic [W-1:0]   root_o,
  output logic [W:0]     rem_o
);
  localparam int CntW = $clog2(W);

  logic [2*W-1:0] op_q;
  logic [W-1:0]   root_q;
  logic [W+1:0]   rem_q;
  logic [CntW-1:0] cnt_q;
  logic           busy_q, done_q;
  logic [W+1:0]   rem_sh, trial;
  logic           ge;

  // two operand bits per step, one root bit out
  assign rem_sh = {rem_q[W-1:0], op_q[2*W-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign ge     = (rem_sh >= trial);

  assign done_o = done_q;
  assign root_o = root_q;
  assign rem_o  = rem_q[W:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        op_q   <= op_i;
        root_q <= '0;
        rem_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q  <= ge ? (rem_sh - trial) : rem_sh;
        root_q <= {root_q[W-2:0], ge};
        op_q   <= {op_q[2*W-3:0], 2'b00};
        cnt_q  <= cnt_q + 1'b1;
        if (cnt_q == CntW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end
endmodule

[rtl/apa_front.sv]
module apa_front (
  apa_pix_if.sink              pix,
  input  apa_pkg::apa_cfg_t    cfg_i,
  input  logic                 full_i,
  output logic                 push_o,
  output apa_pkg::apa_entry_t  entry_o
);
  import apa_pkg::*;

  logic [PixW-1:0]   pm;
  logic signed [15:0] sx, sy, dx2, dy2;
  logic [RsqW-1:0]   rsq;
  logic [DistW-1:0]  d2;

  assign pix.ready = !full_i;
  assign push_o    = pix.valid && !full_i;

  always_comb begin
    pm  = pix.pixel_value & PixMask;
    sx  = {{8{pix.offset_x[7]}}, pix.offset_x};
    sy  = {{8{pix.offset_y[7]}}, pix.offset_y};
    dx2 = sx * sx;
    dy2 = sy * sy;
    rsq = RsqW'(dx2) + RsqW'(dy2);
    d2  = {rsq, 16'h0};

    entry_o.pix     = pm;
    entry_o.rsq     = rsq;
    entry_o.in_ap   = (d2 < cfg_i.outer) && (pm > cfg_i.low) && (pm < cfg_i.high);
    entry_o.on_ring = (d2 >= cfg_i.inner);
    entry_o.last    = pix.last_pixel;
  end
endmodule

[rtl/apa_back.sv]
module apa_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  apa_pkg::apa_cfg_t    cfg_i,
  input  logic                 empty_i,
  input  apa_pkg::apa_entry_t  entry_i,
  output logic                 pop_o,
  apa_res_if.source            res
);
  import apa_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ROOT, ST_ACC, ST_SKY, ST_SIG, ST_VAR, ST_E1, ST_E2,
    ST_Q3, ST_A2, ST_E3, ST_NCHK, ST_NROOT, ST_EMIT
  } state_e;

  localparam logic [5:0] MulLast = 6'd47;
  localparam logic [5:0] DivLast = 6'd55;
  localparam logic signed [40:0] SigMax = 41'sd549755813887;
  localparam logic signed [40:0] SigMin = -41'sd549755813888;

  state_e            state_q;
  apa_entry_t        cur_q;
  logic [FluxW-1:0]  flux_q, fin_flux_q;
  logic [AreaW-1:0]  area_q, fin_area_q;
  logic [39:0]       sky_q;
  logic [47:0]       var_q, ma_q;
  logic [95:0]       p_q;
  logic [55:0]       dq_q;
  logic [15:0]       dr_q, dd_q;
  logic [81:0]       esum_q;
  logic [5:0]        cnt_q;
  logic signed [39:0] sig_q;
  logic [NoiseW-1:0] noise_q;
  logic              ok_q, nok_q;
  logic              out_valid_q;
  logic signed [39:0] out_sig_q;
  logic [NoiseW-1:0] out_noise_q;
  logic [AreaW-1:0]  out_area_q;
  logic              out_ok_q, out_nok_q;

  logic              px_start, px_done, ns_start, ns_done;
  logic [15:0]       px_root;
  logic [16:0]       px_rem;
  logic [39:0]       ns_root;

  logic [16:0]       top17, s17;
  logic [8:0]        w;
  logic [24:0]       wprod;
  logic [40:0]       flux_sum;
  logic [24:0]       area_sum;
  logic [FluxW-1:0]  flux_nx;
  logic [AreaW-1:0]  area_nx;
  logic [47:0]       sky_prod, var_prod, a2_prod;
  logic [48:0]       sky_rnd;
  logic signed [40:0] diff, sig_sat;
  logic [48:0]       msum;
  logic [95:0]       p_nx;
  logic [16:0]       dt;
  logic              dge;
  logic [15:0]       dr_nx;
  logic [55:0]       dq_nx;
  logic              ovf;
  logic              emit;

  assign pop_o    = (state_q == ST_IDLE) && !empty_i;
  assign px_start = pop_o && entry_i.in_ap && entry_i.on_ring;
  assign ovf      = |esum_q[81:80];
  assign ns_start = (state_q == ST_NCHK) && !ovf;
  assign emit     = (state_q == ST_EMIT) && (!out_valid_q || res.ready);

  apa_isqrt #(.W(16)) u_px_sqrt (
    .clk_i, .rst_ni, .start_i(px_start), .op_i({entry_i.rsq, 16'h0}),
    .done_o(px_done), .root_o(px_root), .rem_o(px_rem)
  );

  apa_isqrt #(.W(40)) u_ns_sqrt (
    .clk_i, .rst_ni, .start_i(ns_start), .op_i(esum_q[79:0]),
    .done_o(ns_done), .root_o(ns_root), .rem_o()
  );

  // edge-ring weight and saturating accumulate
  always_comb begin
    top17 = {2'b0, cfg_i.radius} + {9'h0, HalfQ8};
    s17   = {1'b0, px_root} + ((px_rem > {1'b0, px_root}) ? 17'd1 : 17'd0);
    if (!cur_q.in_ap) begin
      w = '0;
    end else if (!cur_q.on_ring) begin
      w = WeightOne;
    end else if (top17 <= s17) begin
      w = '0;
    end else if ((top17 - s17) > {8'h0, WeightOne}) begin
      w = WeightOne;
    end else begin
      w = 9'(top17 - s17);
    end
    wprod    = 25'(w) * 25'(cur_q.pix);
    flux_sum = {1'b0, flux_q} + 41'(wprod);
    area_sum = {1'b0, area_q} + 25'(w);
    flux_nx  = flux_sum[40] ? {FluxW{1'b1}} : flux_sum[39:0];
    area_nx  = area_sum[24] ? {AreaW{1'b1}} : area_sum[23:0];
  end

  always_comb begin
    sky_prod = 48'(cfg_i.sky) * 48'(fin_area_q);
    sky_rnd  = {1'b0, sky_prod} + 49'(HalfQ8);
    diff     = $signed({1'b0, fin_flux_q}) - $signed({1'b0, sky_q});
    if (diff > SigMax) begin
      sig_sat = SigMax;
    end else if (diff < SigMin) begin
      sig_sat = SigMin;
    end else begin
      sig_sat = diff;
    end
    var_prod = 48'(cfg_i.spread) * 48'(cfg_i.spread);
    a2_prod  = 48'(fin_area_q) * 48'(fin_area_q);
    // shift-add multiply, one multiplier bit per cycle
    msum = {1'b0, p_q[95:48]} + (p_q[0] ? {1'b0, ma_q} : 49'h0);
    p_nx = {msum, p_q[47:1]};
    // restoring divide, one quotient bit per cycle
    dt    = {dr_q, dq_q[55]};
    dge   = (dt >= {1'b0, dd_q});
    dr_nx = dge ? 16'(dt - {1'b0, dd_q}) : dt[15:0];
    dq_nx = {dq_q[54:0], dge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      flux_q      <= '0;
      area_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (res.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            cur_q   <= entry_i;
            state_q <= (entry_i.in_ap && entry_i.on_ring) ? ST_ROOT : ST_ACC;
          end
        end
        ST_ROOT: begin
          if (px_done) begin
            state_q <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (cur_q.last) begin
            fin_flux_q <= flux_nx;
            fin_area_q <= area_nx;
            flux_q     <= '0;
            area_q     <= '0;
            state_q    <= ST_SKY;
          end else begin
            flux_q  <= flux_nx;
            area_q  <= area_nx;
            state_q <= ST_IDLE;
          end
        end
        ST_SKY: begin
          sig_q   <= '0;
          noise_q <= '0;
          ok_q    <= 1'b0;
          nok_q   <= 1'b0;
          if (fin_area_q < AreaOne) begin
            state_q <= ST_EMIT;
          end else begin
            sky_q   <= sky_rnd[47:8];
            state_q <= ST_SIG;
          end
        end
        ST_SIG: begin
          sig_q <= sig_sat[39:0];
          ok_q  <= 1'b1;
          if ((sig_sat > 41'sd0) && (cfg_i.gain != '0) && (cfg_i.nsky != '0)) begin
            state_q <= ST_VAR;
          end else begin
            state_q <= ST_EMIT;
          end
        end
        ST_VAR: begin
          var_q   <= var_prod;
          p_q     <= {48'h0, var_prod};
          ma_q    <= 48'(fin_area_q);
          cnt_q   <= '0;
          state_q <= ST_E1;
        end
        ST_E1: begin
          p_q <= p_nx;
          if (cnt_q == MulLast) begin
            esum_q  <= 82'(p_nx[71:8]);
            dq_q    <= 56'({sig_q[38:0], 16'h0});
            dr_q    <= '0;
            dd_q    <= cfg_i.gain;
            cnt_q   <= '0;
            state_q <= ST_E2;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_E2: begin
          if (cnt_q == DivLast) begin
            esum_q  <= esum_q + 82'(dq_nx);
            dq_q    <= 56'(var_q);
            dr_q    <= '0;
            dd_q    <= cfg_i.nsky;
            cnt_q   <= '0;
            state_q <= ST_Q3;
          end else begin
            dq_q  <= dq_nx;
            dr_q  <= dr_nx;
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_Q3: begin
          dq_q  <= dq_nx;
          dr_q  <= dr_nx;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DivLast) begin
            ma_q    <= dq_nx[47:0];
            state_q <= ST_A2;
          end
        end
        ST_A2: begin
          p_q     <= {48'h0, a2_prod};
          cnt_q   <= '0;
          state_q <= ST_E3;
        end
        ST_E3: begin
          p_q   <= p_nx;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == MulLast) begin
            esum_q  <= esum_q + 82'(p_nx[95:16]);
            state_q <= ST_NCHK;
          end
        end
        ST_NCHK: begin
          if (ovf) begin
            noise_q <= {NoiseW{1'b1}};
            nok_q   <= 1'b1;
            state_q <= ST_EMIT;
          end else begin
            state_q <= ST_NROOT;
          end
        end
        ST_NROOT: begin
          if (ns_done) begin
            noise_q <= ns_root;
            nok_q   <= 1'b1;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit) begin
            out_sig_q   <= sig_q;
            out_noise_q <= noise_q;
            out_area_q  <= fin_area_q;
            out_ok_q    <= ok_q;
            out_nok_q   <= nok_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res.valid         = out_valid_q;
  assign res.net_signal    = out_sig_q;
  assign res.noise_level   = out_noise_q;
  assign res.aperture_area = out_area_q;
  assign res.result_valid  = out_ok_q;
  assign res.noise_valid   = out_nok_q;
endmodule

[rtl/aperture_photometry_accumulator.sv]
// Aperture photometry accumulator.
// pix: window pixels with signed offsets from the star center; last_pixel
//   closes the window. res: one result per window, at the last pixel.
// cfg: write cfg_we_i with cfg_idx_i / cfg_data_i; change registers only
//   while no window is in progress and no result is pending.
// Pixels pass a classifier into a two-entry queue; the accumulator drains
//   it. An ordinary pixel passes ST_IDLE and ST_ACC; a pixel on the edge
//   ring waits in ST_ROOT between them for the 16-step square root unit.
// At the last pixel the result is formed in a sequence of states; with
//   noise it uses a serial multiplier (48 steps, used twice), a serial
//   divider (56 steps, used twice) and a 40-step square root.
// A finished result sits in an output register; pixels of the next window
//   keep being accumulated while it waits. A second result waits until the
//   first is transferred, and then the queue backs up to pix.ready.
// Reset clears the sums and loads the register defaults (radius 1.0 pixel,
//   limits 0 and 65535, all others zero).
module aperture_photometry_accumulator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  apa_pix_if.sink                        pix,
  apa_res_if.source                      res,
  input  logic                           cfg_we_i,
  input  logic [apa_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [apa_pkg::CfgDataW-1:0]   cfg_data_i
);
  import apa_pkg::*;

  apa_cfg_t          cfg_q;
  logic [RadW-1:0]   rad_w;
  logic              push, pop, full, empty;
  apa_entry_t        wentry, rentry;

  assign rad_w = clamp_radius(cfg_data_i[RadW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radius <= RadW'(256);
      cfg_q.outer  <= outer_of(RadW'(256));
      cfg_q.inner  <= inner_of(RadW'(256));
      cfg_q.low    <= '0;
      cfg_q.high   <= {LimW{1'b1}};
      cfg_q.sky    <= '0;
      cfg_q.spread <= '0;
      cfg_q.gain   <= '0;
      cfg_q.nsky   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_RADIUS: begin
          cfg_q.radius <= rad_w;
          cfg_q.outer  <= outer_of(rad_w);
          cfg_q.inner  <= inner_of(rad_w);
        end
        CFG_LOW:    cfg_q.low    <= cfg_data_i[LimW-1:0];
        CFG_HIGH:   cfg_q.high   <= cfg_data_i[LimW-1:0];
        CFG_SKY:    cfg_q.sky    <= cfg_data_i[SkyW-1:0];
        CFG_SPREAD: cfg_q.spread <= cfg_data_i[SkyW-1:0];
        CFG_GAIN:   cfg_q.gain   <= cfg_data_i[GainW-1:0];
        CFG_NSKY:   cfg_q.nsky   <= cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  apa_front u_front (
    .pix, .cfg_i(cfg_q), .full_i(full), .push_o(push), .entry_o(wentry)
  );

  apa_fifo #(.Width($bits(apa_entry_t)), .Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .wdata_i(wentry), .full_o(full),
    .pop_i(pop), .rdata_o(rentry), .empty_o(empty)
  );

  apa_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .empty_i(empty), .entry_i(rentry),
    .pop_o(pop), .res
  );
endmodule

[rtl/apa_checker.sv]
module apa_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               res_valid_i,
  input logic               res_ready_i,
  input logic signed [39:0] net_signal_i,
  input logic [39:0]        noise_level_i,
  input logic [23:0]        aperture_area_i,
  input logic               result_valid_i,
  input logic               noise_valid_i
);
  // a stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(net_signal_i)
      && $stable(noise_level_i) && $stable(aperture_area_i))
    else $error("result changed while stalled");

  a_noise_needs_signal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && noise_valid_i |-> result_valid_i && (net_signal_i > 40'sd0))
    else $error("noise flagged without positive signal");

  a_small_area_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !result_valid_i |-> (net_signal_i == 40'sd0)
      && (noise_level_i == 40'd0) && !noise_valid_i)
    else $error("invalid result carries data");

  a_area_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && result_valid_i |-> (aperture_area_i >= 24'd256))
    else $error("result valid with area below one pixel");
endmodule

bind aperture_photometry_accumulator apa_checker u_apa_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .res_valid_i(res.valid),
  .res_ready_i(res.ready),
  .net_signal_i(res.net_signal),
  .noise_level_i(res.noise_level),
  .aperture_area_i(res.aperture_area),
  .result_valid_i(res.result_valid),
  .noise_valid_i(res.noise_valid)
);

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import apa_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 3'd7;
  localparam logic [63:0] Max40 = 64'hFF_FFFF_FFFF;
  localparam logic [63:0] Max24 = 64'hFF_FFFF;

  typedef struct {
    logic signed [39:0] signal;
    logic [39:0]        noise;
    logic [23:0]        area;
    logic               ok;
    logic               noise_ok;
  } photometry_t;

  class photometry_scoreboard;
    logic [63:0] radius = 256, low = 0, high = 65535, sky = 0, spread = 0, gain = 0, nsky = 0;
    logic [63:0] flux = 0, area = 0;
    photometry_t pending[$];
    int errors = 0;
    int windows = 0;
    int noisy = 0;

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] v);
      case (idx)
        CFG_RADIUS: radius = v & 24'h7FFF;
        CFG_LOW:    low = v & 24'hFFFF;
        CFG_HIGH:   high = v & 24'hFFFF;
        CFG_SKY:    sky = v;
        CFG_SPREAD: spread = v;
        CFG_GAIN:   gain = v & 24'hFFFF;
        CFG_NSKY:   nsky = v & 24'hFFFF;
        default: ;
      endcase
    endfunction

    function logic [63:0] root_nearest(logic [63:0] v);
      logic [63:0] r, c;
      r = 0;
      for (int b = 15; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if (c * c <= v) r = c;
      end
      if (v - r * r > r) r++;
      return r;
    endfunction

    function logic [39:0] noise_of(logic [63:0] a, logic [63:0] sig);
      logic [127:0] vr, e1, e2, e3, sum, c, r, a128;
      vr = spread * spread;
      a128 = a;
      e1 = (a128 * vr) >> 8;
      e2 = {64'd0, sig << 16} / gain;
      e3 = ((vr / nsky) * a128 * a128) >> 16;
      sum = e1 + e2 + e3;
      if ((sum >> 80) != 0) return Max40[39:0];
      r = 0;
      for (int b = 39; b >= 0; b--) begin
        c = r | (128'd1 << b);
        if (c * c <= sum) r = c;
      end
      return r[39:0];
    endfunction

    function void note(logic [15:0] pix_v, logic signed [7:0] dx, logic signed [7:0] dy,
                       logic last);
      logic [63:0] rad, d2, outer, inner, w, s, p, skyc;
      longint sig;
      photometry_t e;
      p = pix_v & PixMask;
      rad = (radius > MaxRadius * 256) ? MaxRadius * 256 : radius;
      d2 = (64'(int'(dx) * int'(dx) + int'(dy) * int'(dy))) << 16;
      outer = (rad + 128) * (rad + 128);
      inner = (rad >= 128) ? (rad - 128) * (rad - 128) : (128 - rad) * (128 - rad);
      if (d2 < outer && p > low && p < high) begin
        if (d2 < inner) begin
          w = 256;
        end else begin
          s = root_nearest(d2);
          w = (rad + 128 > s) ? rad + 128 - s : 0;
          if (w > 256) w = 256;
        end
        flux = flux + w * p;
        if (flux > Max40) flux = Max40;
        area = area + w;
        if (area > Max24) area = Max24;
      end
      if (!last) return;
      e = '{signal: '0, noise: '0, area: area[23:0], ok: 1'b0, noise_ok: 1'b0};
      if (area >= 256) begin
        skyc = (sky * area + 128) >> 8;
        sig = longint'(flux) - longint'(skyc);
        if (sig > (64'sd1 <<< 39) - 1) sig = (64'sd1 <<< 39) - 1;
        if (sig < -(64'sd1 <<< 39)) sig = -(64'sd1 <<< 39);
        e.ok = 1'b1;
        e.signal = sig[39:0];
        if (sig > 0 && gain > 0 && nsky > 0) begin
          e.noise = noise_of(area, 64'(sig));
          e.noise_ok = 1'b1;
        end
      end
      pending.push_back(e);
      flux = 0;
      area = 0;
    endfunction

    function void check(photometry_t got);
      photometry_t e;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing expected, got sig %0d area %0d", $realtime,
                 got.signal, got.area);
        errors++;
        return;
      end
      e = pending.pop_front();
      windows++;
      if (e.noise_ok) noisy++;
      if (got.signal !== e.signal) begin
        $display("%0t: net_signal expected %0d got %0d", $realtime, e.signal, got.signal);
        errors++;
      end
      if (got.noise !== e.noise) begin
        $display("%0t: noise_level expected %0d got %0d", $realtime, e.noise, got.noise);
        errors++;
      end
      if (got.area !== e.area) begin
        $display("%0t: aperture_area expected %0d got %0d", $realtime, e.area, got.area);
        errors++;
      end
      if (got.ok !== e.ok) begin
        $display("%0t: result_valid expected %0b got %0b", $realtime, e.ok, got.ok);
        errors++;
      end
      if (got.noise_ok !== e.noise_ok) begin
        $display("%0t: noise_valid expected %0b got %0b", $realtime, e.noise_ok,
                 got.noise_ok);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  int idle_mode = 0;
  int pixels_sent = 0;

  apa_pix_if pix ();
  apa_res_if res ();

  photometry_scoreboard sb = new();

  aperture_photometry_accumulator dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .pix(pix.sink),
    .res(res.source),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("FAIL aperture_photometry_accumulator");
    $finish;
  end

  function automatic bit roll_idle(int pct_a, int pct_b, bit is_sender);
    case (idle_mode)
      0: return $urandom_range(99) < (is_sender ? pct_a : pct_b);
      1: return $urandom_range(99) < (is_sender ? pct_b : pct_a);
      default: return 1'b0;
    endcase
  endfunction

  // result side: random stalls, check every transfer
  initial res.ready = 1'b0;
  always @(negedge clk_i) res.ready <= rst_ni && !roll_idle(37, 87, 1'b0);

  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready)
      sb.check('{signal: res.net_signal, noise: res.noise_level, area: res.aperture_area,
                 ok: res.result_valid, noise_ok: res.noise_valid});
  end

  task automatic send_pixel(logic [15:0] v, logic signed [7:0] dx, logic signed [7:0] dy,
                            logic last);
    bit done;
    done = 1'b0;
    while (!done) begin
      @(negedge clk_i);
      if (roll_idle(37, 87, 1'b1)) begin
        pix.valid = 1'b0;
      end else begin
        pix.valid = 1'b1;
        pix.pixel_value = v;
        pix.offset_x = dx;
        pix.offset_y = dy;
        pix.last_pixel = last;
      end
      @(posedge clk_i);
      if (pix.valid && pix.ready) begin
        sb.note(v, dx, dy, last);
        pixels_sent++;
        done = 1'b1;
      end
    end
    @(negedge clk_i);
    pix.valid = 1'b0;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] v);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = v;
    sb.set_reg(idx, v);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  // one window of random pixels, mostly near the aperture
  task automatic send_window();
    int n, reach;
    logic [15:0] v;
    logic signed [7:0] dx, dy;
    n = $urandom_range(1, 12);
    reach = (sb.radius > MaxRadius * 256) ? MaxRadius + 2 : int'(sb.radius >> 8) + 2;
    if (reach > 127) reach = 127;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        dx = 8'($urandom);
        dy = 8'($urandom);
      end else begin
        dx = 8'(int'($urandom_range(0, 2 * reach)) - reach);
        dy = 8'(int'($urandom_range(0, 2 * reach)) - reach);
      end
      case ($urandom_range(3))
        0: v = sb.low[15:0] + 16'($urandom_range(0, 2)) - 16'd1;
        1: v = sb.high[15:0] + 16'($urandom_range(0, 2)) - 16'd1;
        default: v = 16'($urandom);
      endcase
      send_pixel(v, dx, dy, i == n - 1);
    end
  endtask

  initial begin
    int ph;
    logic [CfgDataW-1:0] lo;
    pix.valid = 1'b0;
    pix.pixel_value = '0;
    pix.offset_x = '0;
    pix.offset_y = '0;
    pix.last_pixel = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: limits exclude 0 and 65535, edge ring, corners, tiny area
    send_pixel(16'd100, 8'sd0, 8'sd0, 1'b0);
    send_pixel(16'hFFFF, 8'sd1, 8'sd0, 1'b0);
    send_pixel(16'd0, 8'sd0, 8'sd1, 1'b0);
    send_pixel(16'd500, 8'sd1, 8'sd1, 1'b0);
    send_pixel(16'd7, -8'sd128, -8'sd128, 1'b0);
    send_pixel(16'd9, 8'sd127, 8'sd127, 1'b0);
    send_pixel(16'd1234, 8'sd0, -8'sd1, 1'b1);
    send_pixel(16'd300, 8'sd1, 8'sd1, 1'b1);
    send_pixel(16'd40, 8'sd0, 8'sd0, 1'b1);
    send_pixel(16'h5AA5, 8'sh55, -8'sd43, 1'b1);
    send_pixel(16'hA55A, -8'sd86, 8'sh2A, 1'b1);

    for (ph = 1; ph < 9; ph++) begin
      idle_mode = ph * 3 / 9;
      drain();
      case (ph)
        1: begin
          // zero radius, widest limits, max gain and sky count
          write_reg(CFG_RADIUS, 0);
          write_reg(CFG_HIGH, 24'hFFFF);
          write_reg(CFG_GAIN, 24'hFFFF);
          write_reg(CFG_NSKY, 24'hFFFF);
          write_reg(CFG_SPREAD, 24'd0);
          write_reg(CFG_SKY, 24'd0);
          write_reg(CFG_LOW, 24'd0);
        end
        2: begin
          // oversized radius saturates; max sky, spread; unit gain and count
          write_reg(CFG_RADIUS, 24'h7FFF);
          write_reg(CFG_SKY, 24'hFFFFFF);
          write_reg(CFG_SPREAD, 24'hFFFFFF);
          write_reg(CFG_GAIN, 24'd1);
          write_reg(CFG_NSKY, 24'd1);
          write_reg(CFG_LOW, 24'hFFFF);
          write_reg(CfgIdxUnused, 24'hFFFFFF);
        end
        3: begin
          write_reg(CFG_RADIUS, 24'd25600);
          write_reg(CFG_LOW, 24'd0);
          write_reg(CFG_HIGH, 24'd0);
          write_reg(CFG_SKY, 24'd0);
        end
        default: begin
          write_reg(CFG_RADIUS, ($urandom_range(3) == 0) ? $urandom_range(0, 32767)
                                                         : $urandom_range(0, 2048));
          lo = $urandom_range(0, 2000);
          write_reg(CFG_LOW, lo);
          write_reg(CFG_HIGH, $urandom_range(lo + 1000, 65535));
          write_reg(CFG_SKY, $urandom_range(0, 1 << 23));
          write_reg(CFG_SPREAD, $urandom);
          write_reg(CFG_GAIN, $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 65535));
          write_reg(CFG_NSKY, $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 65535));
        end
      endcase
      while (pixels_sent < 11 + ph * 112) send_window();
    end

    drain();
    $display("Covered %0d pixels in %0d windows, %0d with noise, over 9 register settings",
             pixels_sent, sb.windows, sb.noisy);
    if (sb.errors == 0) begin
      $display("PASS aperture_photometry_accumulator");
    end else begin
      $display("FAIL aperture_photometry_accumulator");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/apa_pkg.sv
rtl/apa_if.sv
rtl/apa_fifo.sv
rtl/apa_isqrt.sv
rtl/apa_front.sv
rtl/apa_back.sv
rtl/aperture_photometry_accumulator.sv
rtl/apa_checker.sv
test/testbench.sv
